// ===== rtl/atf_pkg.sv =====
// Shared types, constants and helper functions for the accelerometer tilt filter.
package atf_pkg;

  typedef struct packed {
    logic signed [15:0] b0;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] a1;
    logic signed [15:0] a2;
  } atf_coef_t;

  // one calibration row: three gains and an offset, all scaled by 2^32
  typedef struct packed {
    logic signed [23:0] c0;
    logic signed [23:0] c1;
    logic signed [23:0] c2;
    logic signed [28:0] off;
  } cal_row_t;

  typedef enum logic [1:0] {L_IDLE, L_CAL, L_FILT, L_DONE} lane_state_t;
  typedef enum logic [2:0] {
    A_IDLE, A_SQ1, A_SQ2, A_SUM, A_SQRT, A_CORD, A_DIV, A_FIN
  } ang_state_t;
  typedef enum logic [1:0] {T_IDLE, T_LANES, T_ANGLE, T_MERGE} top_state_t;

  localparam logic [3:0] REG_B0       = 4'd0;
  localparam logic [3:0] REG_B1       = 4'd1;
  localparam logic [3:0] REG_B2       = 4'd2;
  localparam logic [3:0] REG_A1       = 4'd3;
  localparam logic [3:0] REG_A2       = 4'd4;
  localparam logic [3:0] REG_TGT_ROLL = 4'd5;
  localparam logic [3:0] REG_TGT_PIT  = 4'd6;
  localparam logic [3:0] REG_DEADBAND = 4'd7;

  localparam cal_row_t CAL_ROWS [3] = '{
    '{-24'sd75846,   24'sd4316296, 24'sd46775,   -29'sd35751808},
    '{24'sd4167418, -24'sd58186,  -24'sd49757,   -29'sd35310848},
    '{24'sd161759,  -24'sd178433,  24'sd4057489, -29'sd161732096}
  };

  localparam logic signed [43:0] SAT_MAX = 44'sd524287;
  localparam logic signed [43:0] SAT_MIN = -44'sd524288;

  function automatic logic signed [19:0] sat20(input logic signed [43:0] v);
    if (v > SAT_MAX) return 20'sd524287;
    if (v < SAT_MIN) return -20'sd524288;
    return v[19:0];
  endfunction

  // atan(2^-i) in 1e-4 degree
  function automatic logic [19:0] atan_lut(input logic [3:0] i);
    case (i)
      4'd0:    return 20'd450000;
      4'd1:    return 20'd265651;
      4'd2:    return 20'd140362;
      4'd3:    return 20'd71250;
      4'd4:    return 20'd35763;
      4'd5:    return 20'd17899;
      4'd6:    return 20'd8952;
      4'd7:    return 20'd4476;
      4'd8:    return 20'd2238;
      4'd9:    return 20'd1119;
      4'd10:   return 20'd560;
      4'd11:   return 20'd280;
      4'd12:   return 20'd140;
      4'd13:   return 20'd70;
      4'd14:   return 20'd35;
      default: return 20'd17;
    endcase
  endfunction

endpackage

// ===== rtl/atf_lane.sv =====
// One axis lane: calibration row, sample window and window-rerun biquad on a shared multiplier.
module atf_lane import atf_pkg::*; #(
  parameter int WINDOW = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               do_filt,
  input  logic signed [15:0] samp0,
  input  logic signed [15:0] samp1,
  input  logic signed [15:0] samp2,
  input  cal_row_t           row,
  input  atf_coef_t          coef,
  output logic               done,
  output logic signed [19:0] filt
);
  localparam int NW = $clog2(WINDOW);

  lane_state_t state, state_next;
  logic [2:0] k;
  logic [NW-1:0] n;
  logic signed [15:0] s0, s1, s2;
  logic filt_en;
  logic signed [19:0] hist [WINDOW];
  logic signed [19:0] x1, x2, y1, y2;
  logic signed [43:0] prod, acc, tot;
  logic signed [23:0] opa;
  logic signed [19:0] opb;
  logic signed [19:0] val;
  logic last_k;

  always_comb begin
    opa = '0;
    opb = '0;
    if (state == L_CAL) begin
      case (k)
        3'd0:    begin opa = row.c0; opb = {{4{s0[15]}}, s0}; end
        3'd1:    begin opa = row.c1; opb = {{4{s1[15]}}, s1}; end
        3'd2:    begin opa = row.c2; opb = {{4{s2[15]}}, s2}; end
        default: begin opa = '0; opb = '0; end
      endcase
    end else begin
      case (k)
        3'd0:    begin opa = {{8{coef.b0[15]}}, coef.b0}; opb = hist[n]; end
        3'd1:    begin opa = {{8{coef.b1[15]}}, coef.b1}; opb = x1; end
        3'd2:    begin opa = {{8{coef.b2[15]}}, coef.b2}; opb = x2; end
        3'd3:    begin opa = {{8{coef.a1[15]}}, coef.a1}; opb = y1; end
        3'd4:    begin opa = {{8{coef.a2[15]}}, coef.a2}; opb = y2; end
        default: begin opa = '0; opb = '0; end
      endcase
    end
    if (state == L_CAL) begin
      tot = acc + prod + {{15{row.off[28]}}, row.off} + 44'sd32768;
      val = sat20(tot >>> 16);
      last_k = (k == 3'd3);
    end else begin
      tot = acc + prod + 44'sd8192;
      val = sat20(tot >>> 14);
      last_k = (k == 3'd5);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      L_IDLE: if (start) state_next = L_CAL;
      L_CAL:  if (last_k) state_next = filt_en ? L_FILT : L_DONE;
      L_FILT: if (last_k && n == NW'(WINDOW - 1)) state_next = L_DONE;
      L_DONE: state_next = L_IDLE;
      default: state_next = L_IDLE;
    endcase
  end

  assign done = (state == L_DONE);

  always_ff @(posedge clk) begin
    if (rst) state <= L_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
      n <= '0;
      for (int i = 0; i < WINDOW; i++) hist[i] <= '0;
    end else begin
      case (state)
        L_IDLE: begin
          if (start) begin
            s0 <= samp0;
            s1 <= samp1;
            s2 <= samp2;
            filt_en <= do_filt;
            k <= '0;
          end
        end
        L_CAL, L_FILT: begin
          prod <= opa * opb;
          acc  <= (k == 3'd0) ? 44'sd0 : acc + prod;
          k    <= k + 3'd1;
          if (last_k) begin
            k <= '0;
            if (state == L_CAL) begin
              for (int i = 0; i < WINDOW - 1; i++) hist[i] <= hist[i + 1];
              hist[WINDOW - 1] <= val;
              n  <= '0;
              x1 <= '0;
              x2 <= '0;
              y1 <= '0;
              y2 <= '0;
            end else begin
              y2   <= y1;
              y1   <= val;
              x2   <= x1;
              x1   <= hist[n];
              n    <= n + NW'(1);
              filt <= val;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/atf_angle.sv =====
// Angle unit: sum of squares, bit-serial square root, 16-step CORDIC atan, tenths rounding.
module atf_angle import atf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [19:0] num,
  input  logic signed [19:0] o1,
  input  logic signed [19:0] o2,
  output logic               done,
  output logic [10:0]        tenths
);
  ang_state_t state, state_next;
  logic [4:0] i;
  logic signed [39:0] sqp;
  logic [39:0] v;
  logic [40:0] r, bitv, trial;
  logic signed [43:0] x, y, dx, dy;
  logic signed [21:0] z;
  logic [19:0] mag, zc, zr;
  logic [40:0] qp;
  logic [9:0] t;

  always_comb begin
    mag   = num[19] ? (~num + 20'd1) : num;
    bitv  = 41'd1 << (6'd38 - {i, 1'b0});
    trial = r + bitv;
    dx    = y >>> i[3:0];
    dy    = x >>> i[3:0];
    if (z < 22'sd0)             zc = '0;
    else if (z > 22'sd900000)   zc = 20'd900000;
    else                        zc = z[19:0];
    zr    = zc + 20'd500;
    t     = qp[39:30];
  end

  always_comb begin
    state_next = state;
    case (state)
      A_IDLE: if (start) state_next = A_SQ1;
      A_SQ1:  state_next = A_SQ2;
      A_SQ2:  state_next = A_SUM;
      A_SUM:  state_next = A_SQRT;
      A_SQRT: if (i == 5'd19) state_next = A_CORD;
      A_CORD: if (i == 5'd15) state_next = A_DIV;
      A_DIV:  state_next = A_FIN;
      A_FIN:  state_next = A_IDLE;
      default: state_next = A_IDLE;
    endcase
  end

  assign done = (state == A_FIN);

  always_ff @(posedge clk) begin
    if (rst) state <= A_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i <= '0;
    end else begin
      case (state)
        A_SQ1: sqp <= o1 * o1;
        A_SQ2: begin
          sqp <= o2 * o2;
          v   <= sqp;
        end
        A_SUM: begin
          v <= v + sqp;
          r <= '0;
          i <= '0;
        end
        A_SQRT: begin
          if ({1'b0, v} >= trial) begin
            v <= v - trial[39:0];
            r <= (r >> 1) + bitv;
          end else begin
            r <= r >> 1;
          end
          i <= i + 5'd1;
          if (i == 5'd19) begin
            i <= '0;
            x <= {4'b0, r[20:1] + ({1'b0, v} >= trial ? bitv[19:0] : 20'd0), 20'b0};
            y <= {4'b0, mag, 20'b0};
            z <= '0;
          end
        end
        A_CORD: begin
          if (!y[43]) begin
            x <= x + dx;
            y <= y - dy;
            z <= z + 22'(atan_lut(i[3:0]));
          end else begin
            x <= x - dx;
            y <= y + dy;
            z <= z - 22'(atan_lut(i[3:0]));
          end
          i <= i + 5'd1;
          if (i == 5'd15) i <= '0;
        end
        A_DIV: qp <= {21'b0, zr} * 41'd1073742;
        A_FIN: begin
          if (num == 20'sd0)  tenths <= '0;
          else if (!num[19])  tenths <= 11'd900 + {1'b0, t};
          else                tenths <= 11'd900 - {1'b0, t};
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/accelerometer_tilt_filter.sv =====
// Top level of the accelerometer tilt filter: three axis lanes, two angle units, merge stage.
// Items pass through the lanes, then the angle units, then the merge stage; the block takes
// no new item until the result has left the merge stage (warm-up items skip the filter and
// angle work). The per-lane multiplier loop over the window, the square root and the CORDIC
// set the time an item takes.
// Synchronous rst clears windows, fill count and handshakes; registers take their defaults.
module accelerometer_tilt_filter import atf_pkg::*; #(
  parameter int WINDOW = 5
) (
  input  logic               clk,
  input  logic               rst,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] sample0,
  input  logic signed [15:0] sample1,
  input  logic signed [15:0] sample2,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic               valid_res,
  output logic [10:0]        pitch_tenths,
  output logic [10:0]        roll_tenths,
  output logic [9:0]         pitch_duty,
  output logic [9:0]         roll_duty,
  // register writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  localparam int FW = $clog2(WINDOW + 1);

  top_state_t state, state_next;
  atf_coef_t coef;
  logic [9:0] target_roll, target_pitch;
  logic [7:0] deadband;
  logic [FW-1:0] fill_count;
  logic in_acc, do_filt, filt_r, ang_start, merge_go;
  logic [2:0] lane_done;
  logic signed [19:0] filt [3];
  logic [1:0] ang_done;
  logic [10:0] p_tenths, r_tenths;

  // |whole degrees - target|, zero inside the deadband; /10 as a reciprocal multiply
  function automatic logic [9:0] duty(input logic [10:0] tn, input logic [9:0] tgt,
                                      input logic [7:0] db);
    logic [21:0] m;
    logic signed [11:0] e;
    logic [10:0] a;
    m = {11'b0, tn} * 22'd1639;
    e = $signed({4'b0, m[21:14]}) - $signed({2'b0, tgt});
    a = e[11] ? 11'(-e) : e[10:0];
    if (a <= {3'b0, db}) return '0;
    return a[9:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != T_IDLE);
  assign in_acc    = in_valid && !in_stall;
  // the item being accepted completes the window
  assign do_filt   = (fill_count + FW'(1) >= FW'(WINDOW));
  assign ang_start = (state == T_LANES) && (&lane_done) && filt_r;
  assign merge_go  = (state == T_MERGE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.b0 <= 16'sd4096;
      coef.b1 <= 16'sd8192;
      coef.b2 <= 16'sd4096;
      coef.a1 <= -16'sd3277;
      coef.a2 <= 16'sd2867;
      target_roll  <= '0;
      target_pitch <= '0;
      deadband     <= 8'd5;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_B0:       coef.b0 <= cfg_data;
        REG_B1:       coef.b1 <= cfg_data;
        REG_B2:       coef.b2 <= cfg_data;
        REG_A1:       coef.a1 <= cfg_data;
        REG_A2:       coef.a2 <= cfg_data;
        REG_TGT_ROLL: target_roll  <= cfg_data[9:0];
        REG_TGT_PIT:  target_pitch <= cfg_data[9:0];
        REG_DEADBAND: deadband     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // three identical lanes, one per calibrated axis
  for (genvar g = 0; g < 3; g++) begin : g_lane
    atf_lane #(.WINDOW(WINDOW)) u_lane (
      .clk     (clk),
      .rst     (rst),
      .start   (in_acc),
      .do_filt (do_filt),
      .samp0   (sample0),
      .samp1   (sample1),
      .samp2   (sample2),
      .row     (CAL_ROWS[g]),
      .coef    (coef),
      .done    (lane_done[g]),
      .filt    (filt[g])
    );
  end

  // pitch from X over the Y/Z magnitude, roll from Y over X/Z
  atf_angle u_pitch (
    .clk    (clk),
    .rst    (rst),
    .start  (ang_start),
    .num    (filt[0]),
    .o1     (filt[1]),
    .o2     (filt[2]),
    .done   (ang_done[0]),
    .tenths (p_tenths)
  );

  atf_angle u_roll (
    .clk    (clk),
    .rst    (rst),
    .start  (ang_start),
    .num    (filt[1]),
    .o1     (filt[0]),
    .o2     (filt[2]),
    .done   (ang_done[1]),
    .tenths (r_tenths)
  );

  always_comb begin
    state_next = state;
    case (state)
      T_IDLE:  if (in_acc) state_next = T_LANES;
      T_LANES: if (&lane_done) state_next = filt_r ? T_ANGLE : T_MERGE;
      T_ANGLE: if (&ang_done) state_next = T_MERGE;
      T_MERGE: if (merge_go) state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= T_IDLE;
      fill_count <= '0;
      filt_r     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        filt_r <= do_filt;
        if (fill_count < FW'(WINDOW)) fill_count <= fill_count + FW'(1);
      end
      if (merge_go) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // merge: warm-up items give an all-zero result
  always_ff @(posedge clk) begin
    if (merge_go) begin
      valid_res    <= filt_r;
      pitch_tenths <= filt_r ? p_tenths : '0;
      roll_tenths  <= filt_r ? r_tenths : '0;
      pitch_duty   <= filt_r ? duty(p_tenths, target_pitch, deadband) : '0;
      roll_duty    <= filt_r ? duty(r_tenths, target_roll, deadband) : '0;
    end
  end

  a_warmup_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> pitch_tenths == 11'd0 && roll_tenths == 11'd0 &&
                                pitch_duty == 10'd0 && roll_duty == 10'd0)
    else $error("warm-up result not zero");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res |-> pitch_tenths <= 11'd1800 && roll_tenths <= 11'd1800)
    else $error("angle out of range");

  a_fill_sat: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FW'(WINDOW))
    else $error("fill count past window");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for accelerometer_tilt_filter: directed table, then random phases.
`timescale 1ns / 100ps

module tb_top import atf_pkg::*; ();

  localparam int WIN   = 5;
  localparam int LIMIT = 1000000;

  typedef struct {
    bit        vres;
    bit [10:0] pitch;
    bit [10:0] roll;
    bit [9:0]  dpitch;
    bit [9:0]  droll;
  } tilt_t;

  typedef struct {
    shortint s0, s1, s2;
    bit      typed;   // expected result is the all-zero warm-up item
  } row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] sample0 = '0, sample1 = '0, sample2 = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               valid_res;
  logic [10:0]        pitch_tenths, roll_tenths;
  logic [9:0]         pitch_duty, roll_duty;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [3:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  accelerometer_tilt_filter #(.WINDOW(WIN)) dut (.*);

  // calibration gains and offsets scaled by 2^32, and CORDIC step angles in 1e-4 degree
  longint CAL_GAIN [3][4] = '{
    '{-75846, 4316296, 46775, -35751808},
    '{4167418, -58186, -49757, -35310848},
    '{161759, -178433, 4057489, -161732096}
  };
  longint STEP_ANGLE [16] = '{450000, 265651, 140362, 71250, 35763, 17899, 8952, 4476,
                              2238, 1119, 560, 280, 140, 70, 35, 17};

  // predictor's own copy of the block's registers and windows
  longint    k_b0 = 4096, k_b1 = 8192, k_b2 = 4096, k_a1 = -3277, k_a2 = 2867;
  bit [9:0]  aim_roll = '0, aim_pitch = '0;
  bit [7:0]  band = 8'd5;
  longint    win_x [WIN], win_y [WIN], win_z [WIN];
  int        filled = 0;

  tilt_t     pending_tilt [$];
  int        errors = 0;
  int        cycles = 0;
  int        tx_pct = 0, rx_pct = 0;
  int        hold = 0;
  bit        hold_req = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Q3.16 saturation
  function automatic longint clip20(longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  function automatic longint calib(int row, longint a, longint b, longint c);
    longint acc;
    acc = CAL_GAIN[row][0] * a + CAL_GAIN[row][1] * b + CAL_GAIN[row][2] * c
          + CAL_GAIN[row][3];
    return clip20((acc + 32768) >>> 16);
  endfunction

  // rerun the biquad over the window from rest, keep the last output
  function automatic longint biquad_last(longint h [WIN]);
    longint y [WIN];
    longint acc;
    for (int n = 0; n < WIN; n++) begin
      acc = k_b0 * h[n];
      if (n >= 1) acc += k_b1 * h[n-1] + k_a1 * y[n-1];
      if (n >= 2) acc += k_b2 * h[n-2] + k_a2 * y[n-2];
      y[n] = clip20((acc + 8192) >>> 14);
    end
    return y[WIN-1];
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // 90 + atan(num / |(o1,o2)|) in tenths; a zero numerator reads as 0
  function automatic longint tilt_tenths(longint num, longint o1, longint o2);
    longint x, y, z, dx, dy, t;
    if (num == 0) return 0;
    x = longint'(root_floor(o1 * o1 + o2 * o2)) * 1048576;
    y = (num < 0 ? -num : num) * 1048576;
    z = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += STEP_ANGLE[i];
      end else begin
        x -= dx; y += dy; z -= STEP_ANGLE[i];
      end
    end
    if (z < 0) z = 0;
    if (z > 900000) z = 900000;
    t = (z + 500) / 1000;
    return num > 0 ? 900 + t : 900 - t;
  endfunction

  function automatic bit [9:0] servo_duty(longint tenths, bit [9:0] aim);
    longint e;
    e = tenths / 10 - longint'(aim);
    if (e < 0) e = -e;
    if (e <= longint'(band)) return '0;
    return e[9:0];
  endfunction

  // advance the windows by one item and return its tilt result
  function automatic tilt_t tilt_of(shortint a, shortint b, shortint c);
    tilt_t  r;
    longint fx, fy, fz, p, q;
    for (int i = 0; i + 1 < WIN; i++) begin
      win_x[i] = win_x[i+1];
      win_y[i] = win_y[i+1];
      win_z[i] = win_z[i+1];
    end
    win_x[WIN-1] = calib(0, a, b, c);
    win_y[WIN-1] = calib(1, a, b, c);
    win_z[WIN-1] = calib(2, a, b, c);
    if (filled < WIN) filled++;
    r = '{default: 0};
    if (filled < WIN) return r;
    fx = biquad_last(win_x);
    fy = biquad_last(win_y);
    fz = biquad_last(win_z);
    p = tilt_tenths(fx, fy, fz);
    q = tilt_tenths(fy, fx, fz);
    r.vres   = 1'b1;
    r.pitch  = p[10:0];
    r.roll   = q[10:0];
    r.dpitch = servo_duty(p, aim_pitch);
    r.droll  = servo_duty(q, aim_roll);
    return r;
  endfunction

  // one register write, mirrored into the predictor
  task automatic write_reg(logic [3:0] idx, logic [15:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_B0:       k_b0 = longint'($signed(val));
      REG_B1:       k_b1 = longint'($signed(val));
      REG_B2:       k_b2 = longint'($signed(val));
      REG_A1:       k_a1 = longint'($signed(val));
      REG_A2:       k_a2 = longint'($signed(val));
      REG_TGT_ROLL: aim_roll = val[9:0];
      REG_TGT_PIT:  aim_pitch = val[9:0];
      REG_DEADBAND: band = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all(logic [15:0] b0, logic [15:0] b1, logic [15:0] b2,
                           logic [15:0] a1, logic [15:0] a2,
                           logic [15:0] troll, logic [15:0] tpitch, logic [15:0] db);
    write_reg(REG_B0, b0);
    write_reg(REG_B1, b1);
    write_reg(REG_B2, b2);
    write_reg(REG_A1, a1);
    write_reg(REG_A2, a2);
    write_reg(REG_TGT_ROLL, troll);
    write_reg(REG_TGT_PIT, tpitch);
    write_reg(REG_DEADBAND, db);
  endtask

  // offer one item from a falling edge, with random gaps ahead of it
  task automatic send_item(shortint a, shortint b, shortint c, bit typed);
    tilt_t r;
    while ($urandom_range(99) < tx_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    sample0  = a;
    sample1  = b;
    sample2  = c;
    do @(posedge clk); while (in_stall);
    r = tilt_of(a, b, c);
    if (typed) r = '{default: 0};
    pending_tilt.push_back(r);
    @(negedge clk);
  endtask

  // mostly plausible readings around 1 g, some full-range and some rail values
  function automatic shortint pick_reading();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return shortint'($urandom_range(2400) - 1200);
    if (sel < 85) return shortint'($urandom_range(65535));
    case ($urandom_range(3))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'shFFFF;
    endcase
  endfunction

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) send_item(pick_reading(), pick_reading(), pick_reading(), 1'b0);
    in_valid = 1'b0;
  endtask

  // everything out, then a short settle, before touching the registers
  task automatic drain();
    in_valid = 1'b0;
    rx_pct = 0;
    while (pending_tilt.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // receiver: random stalls, or a long hold-off when asked
  always @(negedge clk) begin
    if (hold_req) begin
      hold = 600;
      hold_req = 1'b0;
    end
    if (hold > 0) begin
      out_stall = 1'b1;
      hold--;
    end else begin
      out_stall = ($urandom_range(99) < rx_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    tilt_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_tilt.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        e = pending_tilt.pop_front();
        if (valid_res !== e.vres) begin
          $error("valid_res: expected %0d, got %0d", e.vres, valid_res);
          errors++;
        end
        if (pitch_tenths !== e.pitch) begin
          $error("pitch_tenths: expected %0d, got %0d", e.pitch, pitch_tenths);
          errors++;
        end
        if (roll_tenths !== e.roll) begin
          $error("roll_tenths: expected %0d, got %0d", e.roll, roll_tenths);
          errors++;
        end
        if (pitch_duty !== e.dpitch) begin
          $error("pitch_duty: expected %0d, got %0d", e.dpitch, pitch_duty);
          errors++;
        end
        if (roll_duty !== e.droll) begin
          $error("roll_duty: expected %0d, got %0d", e.droll, roll_duty);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("accelerometer_tilt_filter verification failed");
      $finish;
    end
  end

  row_t rows [17] = '{
    // warm-up: first WINDOW-1 items read back all zero
    '{16'sh0000, 16'sh0000, 16'sh0000, 1'b1},
    '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1},
    '{16'sh8000, 16'sh8000, 16'sh8000, 1'b1},
    '{16'sd1000, 16'sd0,    16'sd0,    1'b1},
    // level, each axis up and down, then rails and saturation
    '{16'sd0,    16'sd0,    16'sd1000, 1'b0},
    '{16'sd0,    16'sd1000, 16'sd0,    1'b0},
    '{16'sd1000, 16'sd0,    16'sd0,    1'b0},
    '{-16'sd1000, 16'sd0,   16'sd0,    1'b0},
    '{16'sd0,   -16'sd1000, 16'sd0,    1'b0},
    '{16'sd0,    16'sd0,   -16'sd1000, 1'b0},
    '{16'sh7FFF, 16'sh8000, 16'sh0000, 1'b0},
    '{16'sh8000, 16'sh7FFF, 16'sh8000, 1'b0},
    '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0},
    '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0},
    '{16'sd0,    16'sd0,    16'sd0,    1'b0},
    '{16'sd1,   -16'sd1,    16'sd1,    1'b0},
    '{16'sd16384, -16'sd16384, 16'sd8192, 1'b0}
  };

  initial begin
    for (int i = 0; i < WIN; i++) begin
      win_x[i] = 0; win_y[i] = 0; win_z[i] = 0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table at reset settings, no idling
    foreach (rows[i]) send_item(rows[i].s0, rows[i].s1, rows[i].s2, rows[i].typed);
    drain();

    // defaults with level targets and no deadband; sender idles
    write_all(16'd4096, 16'd8192, 16'd4096, -16'sd3277, 16'd2867, 16'd90, 16'd90, 16'd0);
    tx_pct = 59;
    send_random(400);
    drain();

    // coefficient extremes, targets at 1023 and 999, widest deadband; receiver stalls
    // and holds off long enough for the block to back up into its input
    write_all(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd1023, 16'd999, 16'd255);
    tx_pct = 0;
    rx_pct = 59;
    hold_req = 1'b1;
    send_random(300);
    drain();

    // all-zero filter: every filtered axis is zero, so both angles read 0
    write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    tx_pct = 18;
    rx_pct = 18;
    send_random(100);
    drain();

    // unity pass-through on the newest sample; out-of-range index is ignored
    write_all(16'd16384, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd45, 16'd10);
    write_reg(4'd9, 16'hFFFF);
    tx_pct = 0;
    send_random(300);
    drain();

    // random settings, each idling pattern in turn
    for (int ph = 0; ph < 4; ph++) begin
      write_all(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                16'($urandom_range(65535)), 16'($urandom_range(65535)),
                16'($urandom_range(65535)), 16'($urandom_range(1023)),
                16'($urandom_range(1023)), 16'($urandom_range(255)));
      tx_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 18 : 59) : 0;
      rx_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 18 : 59) : 0;
      send_random(150);
      drain();
    end

    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("accelerometer_tilt_filter verification clean");
    end else begin
      $display("accelerometer_tilt_filter verification failed");
    end
    $finish;
  end

endmodule
